>>> rtl/core/led_fade_envelope_sequencer_core_defines.svh
// assertion macros for the fade sequencer core
`ifndef LED_FADE_ENVELOPE_SEQUENCER_CORE_DEFINES_SVH
`define LED_FADE_ENVELOPE_SEQUENCER_CORE_DEFINES_SVH

`ifndef SYNTH

// checked only outside reset
`define LFES_ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lfes assertion failed");

// checked at every edge, reset included
`define LFES_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("lfes assertion failed");

`else

`define LFES_ASSERT_CLK(lbl, prop)
`define LFES_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

>>> rtl/core/lfes_pkg.sv
package lfes_pkg;

    localparam int NUM_CHANNELS = 3;
    localparam int OUT_FIELDS   = 3;

    localparam int TIME_W  = 16;
    localparam int LEVEL_W = 8;
    localparam int PHASE_W = 3;
    localparam int IDX_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // request kinds
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_START = 1'b1;

    // channel phases
    localparam logic [PHASE_W-1:0] PH_IDLE = 3'd0;
    localparam logic [PHASE_W-1:0] PH_UP   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_HIGH = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DOWN = 3'd3;
    localparam logic [PHASE_W-1:0] PH_LOW  = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_UP_STEP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UP_TOTAL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_HOLD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_STEP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_TOTAL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_HOLD   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL  = 3'd7;

    typedef struct packed {
        logic [TIME_W-1:0]  up_step;
        logic [TIME_W-1:0]  up_total;
        logic [TIME_W-1:0]  high_hold;
        logic [TIME_W-1:0]  down_step;
        logic [TIME_W-1:0]  down_total;
        logic [TIME_W-1:0]  low_hold;
        logic [LEVEL_W-1:0] max_level;
        logic [LEVEL_W-1:0] min_level;
    } cfg_t;

    typedef struct packed {
        logic tick;
        logic start;
    } chan_cmd_t;

    typedef struct packed {
        logic               active;
        logic [LEVEL_W-1:0] duty_next;
        logic [PHASE_W-1:0] phase_next;
    } chan_view_t;

endpackage

>>> rtl/core/lfes_if.sv
interface lfes_req_if
    import lfes_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             req_type;
    logic [IDX_W-1:0] led_index;

    modport source (output valid, req_type, led_index, input ready);
    modport sink (input valid, req_type, led_index, output ready);
endinterface

interface lfes_res_if
    import lfes_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] duty_zero;
    logic [LEVEL_W-1:0] duty_one;
    logic [LEVEL_W-1:0] duty_two;
    logic [PHASE_W-1:0] phase_zero;
    logic [PHASE_W-1:0] phase_one;
    logic [PHASE_W-1:0] phase_two;
    logic               busy_start;

    modport source (
        output valid, duty_zero, duty_one, duty_two,
               phase_zero, phase_one, phase_two, busy_start,
        input  ready
    );
    modport sink (
        input  valid, duty_zero, duty_one, duty_two,
               phase_zero, phase_one, phase_two, busy_start,
        output ready
    );
endinterface

>>> rtl/core/lfes_chan.sv
module lfes_chan
    import lfes_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  chan_cmd_t  cmd,
    output chan_view_t view
);

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [LEVEL_W-1:0] duty_reg, duty_next;
    logic [TIME_W-1:0]  step_left_reg, step_left_next;
    logic [TIME_W-1:0]  phase_left_reg, phase_left_next;

    logic [TIME_W-1:0]  step_dec;
    logic [TIME_W-1:0]  phase_dec;
    logic               step_done;
    logic               phase_done;
    logic [LEVEL_W-1:0] level_inc;
    logic [LEVEL_W-1:0] level_dec;

    // countdowns hold at zero and expire when they reach zero
    assign step_dec   = (step_left_reg == '0) ? '0 : step_left_reg - TIME_W'(1);
    assign phase_dec  = (phase_left_reg == '0) ? '0 : phase_left_reg - TIME_W'(1);
    assign step_done  = (step_dec == '0);
    assign phase_done = (phase_dec == '0);

    // saturating level moves
    assign level_inc = (level_reg == '1) ? level_reg : level_reg + LEVEL_W'(1);
    assign level_dec = (level_reg == '0) ? level_reg : level_reg - LEVEL_W'(1);

    always_comb
    begin
        phase_next      = phase_reg;
        level_next      = level_reg;
        duty_next       = duty_reg;
        step_left_next  = step_left_reg;
        phase_left_next = phase_left_reg;
        if (cmd.start)
        begin
            phase_next      = PH_UP;
            level_next      = cfg.min_level;
            duty_next       = cfg.min_level;
            step_left_next  = cfg.up_step;
            phase_left_next = cfg.up_total;
        end
        else if (cmd.tick)
        begin
            unique case (phase_reg)
                PH_UP:
                begin
                    step_left_next = step_dec;
                    if (step_done)
                    begin
                        step_left_next = cfg.up_step;
                        duty_next      = level_reg;
                        level_next     = level_inc;
                    end
                    phase_left_next = phase_dec;
                    if (phase_done)
                    begin
                        phase_next      = PH_HIGH;
                        phase_left_next = cfg.high_hold;
                        level_next      = cfg.max_level;
                        duty_next       = cfg.max_level;
                    end
                end
                PH_HIGH:
                begin
                    phase_left_next = phase_dec;
                    if (phase_done)
                    begin
                        phase_next      = PH_DOWN;
                        duty_next       = level_reg;
                        level_next      = level_dec;
                        step_left_next  = cfg.down_step;
                        phase_left_next = cfg.down_total;
                    end
                end
                PH_DOWN:
                begin
                    step_left_next = step_dec;
                    if (step_done)
                    begin
                        step_left_next = cfg.down_step;
                        duty_next      = level_reg;
                        level_next     = level_dec;
                    end
                    phase_left_next = phase_dec;
                    if (phase_done)
                    begin
                        phase_next      = PH_LOW;
                        level_next      = cfg.min_level;
                        duty_next       = cfg.min_level;
                        phase_left_next = cfg.low_hold;
                    end
                end
                PH_LOW:
                begin
                    phase_left_next = phase_dec;
                    if (phase_done)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            level_reg      <= '0;
            duty_reg       <= '0;
            step_left_reg  <= '0;
            phase_left_reg <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            level_reg      <= level_next;
            duty_reg       <= duty_next;
            step_left_reg  <= step_left_next;
            phase_left_reg <= phase_left_next;
        end
    end

    assign view.active     = (phase_reg != PH_IDLE);
    assign view.duty_next  = duty_next;
    assign view.phase_next = phase_next;

endmodule

>>> rtl/core/led_fade_envelope_sequencer_core.sv
// channel  dir  beat contents
// req      in   req_type, led_index
// res      out  duty_zero..two, phase_zero..two, busy_start
// cfg      in   cfg_we, cfg_index, cfg_data (write only)
//
// one beat per cycle while res is ready; req goes via input then result register
// ticks advance all channels in parallel, between input and result registers
// reset sets every channel idle at level zero and loads the register defaults
// a stalled res holds its beat while one more req beat waits in the input register
module led_fade_envelope_sequencer_core
    import lfes_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    lfes_req_if.sink              req,
    lfes_res_if.source            res,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "led_fade_envelope_sequencer_core_defines.svh"

    cfg_t cfg_reg, cfg_next;

    logic             in_vld_reg, in_vld_next;
    logic             in_type_reg;
    logic [IDX_W-1:0] in_idx_reg;

    logic               out_vld_reg, out_vld_next;
    logic [LEVEL_W-1:0] out_duty_reg  [OUT_FIELDS];
    logic [PHASE_W-1:0] out_phase_reg [OUT_FIELDS];
    logic               out_busy_reg;

    logic       req_take;
    logic       move;
    chan_cmd_t  cmd  [NUM_CHANNELS];
    chan_view_t view [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] busy_vec;

    // register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_UP_STEP:    cfg_next.up_step    = cfg_data;
                REG_UP_TOTAL:   cfg_next.up_total   = cfg_data;
                REG_HIGH_HOLD:  cfg_next.high_hold  = cfg_data;
                REG_DOWN_STEP:  cfg_next.down_step  = cfg_data;
                REG_DOWN_TOTAL: cfg_next.down_total = cfg_data;
                REG_LOW_HOLD:   cfg_next.low_hold   = cfg_data;
                REG_MAX_LEVEL:  cfg_next.max_level  = cfg_data[LEVEL_W-1:0];
                REG_MIN_LEVEL:  cfg_next.min_level  = cfg_data[LEVEL_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.up_step    <= TIME_W'(5);
            cfg_reg.up_total   <= TIME_W'(500);
            cfg_reg.high_hold  <= TIME_W'(500);
            cfg_reg.down_step  <= TIME_W'(5);
            cfg_reg.down_total <= TIME_W'(500);
            cfg_reg.low_hold   <= TIME_W'(0);
            cfg_reg.max_level  <= LEVEL_W'(100);
            cfg_reg.min_level  <= LEVEL_W'(0);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // handshake
    assign move      = in_vld_reg && (!out_vld_reg || res.ready);
    assign req.ready = !in_vld_reg || move;
    assign req_take  = req.valid && req.ready;

    assign in_vld_next  = req_take ? 1'b1 : (move ? 1'b0 : in_vld_reg);
    assign out_vld_next = move ? 1'b1 : (res.ready ? 1'b0 : out_vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            in_type_reg <= req.req_type;
            in_idx_reg  <= req.led_index;
        end
    end

    // channels
    for (genvar g = 0; g < NUM_CHANNELS; g++)
    begin : g_chan
        assign cmd[g].tick  = move && (in_type_reg == REQ_TICK);
        assign cmd[g].start = move && (in_type_reg == REQ_START) && (int'(in_idx_reg) == g);
        assign busy_vec[g]  = cmd[g].start && view[g].active;

        lfes_chan u_chan (
            .clk   (clk),
            .rst_n (rst_n),
            .cfg   (cfg_reg),
            .cmd   (cmd[g]),
            .view  (view[g])
        );
    end

    // result register, missing channels read zero
    for (genvar f = 0; f < OUT_FIELDS; f++)
    begin : g_out
        if (f < NUM_CHANNELS)
        begin : g_live
            always_ff @(posedge clk)
            begin
                if (move)
                begin
                    out_duty_reg[f]  <= view[f].duty_next;
                    out_phase_reg[f] <= view[f].phase_next;
                end
            end
        end
        else
        begin : g_none
            always_ff @(posedge clk)
            begin
                if (move)
                begin
                    out_duty_reg[f]  <= '0;
                    out_phase_reg[f] <= PH_IDLE;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_busy_reg <= |busy_vec;
        end
    end

    assign res.valid      = out_vld_reg;
    assign res.duty_zero  = out_duty_reg[0];
    assign res.duty_one   = out_duty_reg[1];
    assign res.duty_two   = out_duty_reg[2];
    assign res.phase_zero = out_phase_reg[0];
    assign res.phase_one  = out_phase_reg[1];
    assign res.phase_two  = out_phase_reg[2];
    assign res.busy_start = out_busy_reg;

    // a beat leaving the input register always lands in the result register
    `LFES_ASSERT_CLK(a_move_lands, move |=> out_vld_reg)
    // input side only stalls while a beat is parked
    `LFES_ASSERT_ALWAYS(a_stall_parked, !req.ready |-> in_vld_reg)
    // a tick never reports a busy start
    `LFES_ASSERT_CLK(a_tick_not_busy, (move && (in_type_reg == REQ_TICK)) |=> !out_busy_reg)

endmodule
